/* hw/rtl/cw_pkg.sv */
// Shared types and constants for the text console writer.
package cw_pkg;

	localparam logic [2:0] KIND_PUT   = 3'd0;
	localparam logic [2:0] KIND_SETCUR = 3'd1;
	localparam logic [2:0] KIND_CLEAR = 3'd2;
	localparam logic [2:0] KIND_BLANK = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	localparam logic [7:0] CH_NEWLINE  = 8'd10;
	localparam logic [7:0] CH_RETURN   = 8'd13;
	localparam logic [7:0] CH_SPACE    = 8'd32;
	localparam logic [7:0] RESET_COLOR = 8'd7;

	localparam int CELL_W  = 16;
	localparam int Q_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_RETURN,
		OP_SETCUR,
		OP_CLEAR,
		OP_BLANK,
		OP_READ,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic [4:0] row;
		logic [6:0] col;
		logic       row_ok;
		logic       col_ok;
	} cmd_t;

endpackage

/* hw/rtl/text_console_writer.sv */
// Top level of the text console writer: color register, front end, queue, execution unit.
// Commands are taken when start is high and busy is low; each one yields exactly one
// result, shown for a single cycle with done high, and the receiver cannot hold it off.
// A command is written into the queue when it is taken, and its result is registered in
// the execution unit. The unit handles a put, newline, return, set cursor, blank or unused
// kind directly, a read through the screen memory's registered read port, and a put or
// newline that scrolls by blanking the new bottom line, one cell a cycle through the
// screen memory's single write port; a clear screen blanks every cell the same way. A
// two-entry queue takes further commands while the unit works; busy is high when it is
// full. After reset, busy stays high while the screen memory is swept to blanks. The
// color register is written through the cfg channel, which is always ready.
module text_console_writer import cw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [7:0]  char_code,
	input  logic [4:0]  row_in,
	input  logic [6:0]  col_in,
	output logic        done,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic [10:0] cursor_offset,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic [7:0] color_q;
	logic       q_full;
	logic       init_busy;
	logic       push;
	cmd_t       push_cmd;
	logic       q_pop;
	logic       q_valid;
	cmd_t       q_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			color_q <= cfg_data;
		end
	end

	cw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.start    (start),
		.kind     (kind),
		.char_code(char_code),
		.row_in   (row_in),
		.col_in   (col_in),
		.q_full   (q_full),
		.init_busy(init_busy),
		.busy     (busy),
		.push     (push),
		.cmd      (push_cmd)
	);

	cw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_data (q_cmd)
	);

	cw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.color        (color_q),
		.q_valid      (q_valid),
		.q_data       (q_cmd),
		.q_pop        (q_pop),
		.init_busy    (init_busy),
		.done         (done),
		.cell_char    (cell_char),
		.cell_attr    (cell_attr),
		.cursor_row   (cursor_row),
		.cursor_col   (cursor_col),
		.cursor_offset(cursor_offset)
	);

endmodule

/* hw/rtl/cw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/cw_front.sv */
// Front end: takes commands and classifies them into queued operations.
module cw_front import cw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic       start,
	input  logic [2:0] kind,
	input  logic [7:0] char_code,
	input  logic [4:0] row_in,
	input  logic [6:0] col_in,
	input  logic       q_full,
	input  logic       init_busy,
	output logic       busy,
	output logic       push,
	output cmd_t       cmd
);

	op_t op;

	always_comb begin
		unique case (kind)
			KIND_PUT: begin
				if (char_code == CH_NEWLINE) begin
					op = OP_NEWLINE;
				end else if (char_code == CH_RETURN) begin
					op = OP_RETURN;
				end else begin
					op = OP_PUT;
				end
			end
			KIND_SETCUR: op = OP_SETCUR;
			KIND_CLEAR:  op = OP_CLEAR;
			KIND_BLANK:  op = OP_BLANK;
			KIND_READ:   op = OP_READ;
			default:     op = OP_NOP;
		endcase
	end

	assign cmd.op     = op;
	assign cmd.ch     = char_code;
	assign cmd.row    = row_in;
	assign cmd.col    = col_in;
	assign cmd.row_ok = 32'(row_in) < ROWS;
	assign cmd.col_ok = 32'(col_in) < COLUMNS;

	assign busy = q_full || init_busy;
	assign push = start && !busy;

endmodule

/* hw/rtl/cw_queue.sv */
// Short command queue between front end and execution unit.
module cw_queue import cw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output cmd_t pop_data
);

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int NW = $clog2(Q_DEPTH + 1);

	cmd_t          entry_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = count_q == NW'(Q_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hw/rtl/cw_back.sv */
// Execution unit: cursor, screen memory, scroll and fill sequencer, results.
module cw_back import cw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  color,
	input  logic        q_valid,
	input  cmd_t        q_data,
	output logic        q_pop,
	output logic        init_busy,
	output logic        done,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic [10:0] cursor_offset
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_FILL = 3'b100
	} state_t;

	state_t            state_q;
	logic [RW-1:0]     cur_row_q;
	logic [CW-1:0]     cur_col_q;
	logic [RW-1:0]     top_q;
	logic [AW-1:0]     fill_addr_q;
	logic [AW-1:0]     fill_end_q;
	logic [7:0]        fill_attr_q;
	logic              fill_emit_q;
	logic              done_q;
	logic [7:0]        res_char_q;
	logic [7:0]        res_attr_q;
	logic [RW-1:0]     res_row_q;
	logic [CW-1:0]     res_col_q;
	logic [AW-1:0]     res_off_q;

	logic [RW:0]       row_inc;
	logic [CW:0]       col_inc;
	logic [RW-1:0]     sel_row;
	logic [CW-1:0]     sel_col;
	logic [RW:0]       sum_row;
	logic [RW-1:0]     phys_row;
	logic [AW-1:0]     op_addr;
	logic [RW-1:0]     top_next;
	logic [AW-1:0]     scroll_base;
	logic [RW:0]       row_nx;
	logic [RW-1:0]     nr;
	logic [CW-1:0]     nc;
	logic [AW-1:0]     nr_off;
	logic              op_we;
	logic [CELL_W-1:0] op_wdata;
	logic              do_scroll;
	logic              do_clear;
	logic              do_read;
	logic              in_range;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [CELL_W-1:0] ram_rdata;

	assign in_range = q_data.row_ok && q_data.col_ok;
	assign row_inc  = (RW+1)'(cur_row_q) + 1'b1;
	assign col_inc  = (CW+1)'(cur_col_q) + 1'b1;

	// Screen rows live in a circular buffer; top_q is the physical row shown first.
	assign sel_row  = (q_data.op == OP_PUT) ? cur_row_q : RW'(q_data.row);
	assign sel_col  = (q_data.op == OP_PUT) ? cur_col_q : CW'(q_data.col);
	assign sum_row  = (RW+1)'(sel_row) + (RW+1)'(top_q);
	assign phys_row = (sum_row >= (RW+1)'(ROWS)) ? RW'(sum_row - (RW+1)'(ROWS))
		: RW'(sum_row);
	assign op_addr  = AW'(phys_row) * AW'(COLUMNS) + AW'(sel_col);

	assign top_next    = (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
	assign scroll_base = AW'(top_q) * AW'(COLUMNS);

	always_comb begin
		row_nx   = (RW+1)'(cur_row_q);
		nc       = cur_col_q;
		op_we    = 1'b0;
		op_wdata = {color, q_data.ch};
		do_clear = 1'b0;
		do_read  = 1'b0;
		unique case (q_data.op)
			OP_PUT: begin
				op_we = 1'b1;
				if (col_inc == (CW+1)'(COLUMNS)) begin
					nc     = '0;
					row_nx = row_inc;
				end else begin
					nc = CW'(col_inc);
				end
			end
			OP_NEWLINE: begin
				row_nx = row_inc;
				nc     = '0;
			end
			OP_RETURN: begin
				nc = '0;
			end
			OP_SETCUR: begin
				row_nx = q_data.row_ok ? (RW+1)'(q_data.row) : (RW+1)'(ROWS - 1);
				nc     = q_data.col_ok ? CW'(q_data.col) : CW'(COLUMNS - 1);
			end
			OP_CLEAR: begin
				row_nx   = '0;
				nc       = '0;
				do_clear = 1'b1;
			end
			OP_BLANK: begin
				op_we    = in_range;
				op_wdata = {color, CH_SPACE};
			end
			OP_READ: begin
				do_read = in_range;
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	assign do_scroll = row_nx == (RW+1)'(ROWS);
	assign nr        = do_scroll ? RW'(ROWS - 1) : RW'(row_nx);
	assign nr_off    = AW'(nr) * AW'(COLUMNS) + AW'(nc);

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign init_busy = (state_q == S_FILL) && !fill_emit_q;

	assign ram_we    = (state_q == S_FILL) || (q_pop && op_we);
	assign ram_waddr = (state_q == S_FILL) ? fill_addr_q : op_addr;
	assign ram_wdata = (state_q == S_FILL) ? {fill_attr_q, CH_SPACE} : op_wdata;

	cw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(op_addr),
		.rdata(ram_rdata)
	);

	// After reset the fill sequencer blanks the whole screen before any command runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			top_q       <= '0;
			fill_addr_q <= '0;
			fill_end_q  <= AW'(CELLS - 1);
			fill_attr_q <= RESET_COLOR;
			fill_emit_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_row_q <= nr;
						cur_col_q <= nc;
						if (do_clear) begin
							top_q       <= '0;
							fill_addr_q <= '0;
							fill_end_q  <= AW'(CELLS - 1);
							fill_attr_q <= color;
							fill_emit_q <= 1'b1;
							state_q     <= S_FILL;
						end else if (do_scroll) begin
							// new bottom line is the old top physical row
							top_q       <= top_next;
							fill_addr_q <= scroll_base;
							fill_end_q  <= scroll_base + AW'(COLUMNS - 1);
							fill_attr_q <= color;
							fill_emit_q <= 1'b1;
							state_q     <= S_FILL;
						end else if (do_read) begin
							state_q <= S_READ;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_READ: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FILL: begin
					fill_addr_q <= fill_addr_q + 1'b1;
					if (fill_addr_q == fill_end_q) begin
						done_q  <= fill_emit_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_char_q <= '0;
			res_attr_q <= '0;
			res_row_q  <= nr;
			res_col_q  <= nc;
			res_off_q  <= nr_off;
		end else if (state_q == S_READ) begin
			res_char_q <= ram_rdata[7:0];
			res_attr_q <= ram_rdata[15:8];
		end
	end

	assign done          = done_q;
	assign cell_char     = res_char_q;
	assign cell_attr     = res_attr_q;
	assign cursor_row    = 5'(res_row_q);
	assign cursor_col    = 7'(res_col_q);
	assign cursor_offset = 11'(res_off_q);

endmodule
